@@ rtl/hbri_pkg.sv @@
`timescale 1ns / 1ps

package hbri_pkg;

    // Direction codes as they appear on the result channel.
    localparam logic [1:0] DIR_STOP = 2'd0;
    localparam logic [1:0] DIR_FWD  = 2'd1;
    localparam logic [1:0] DIR_REV  = 2'd2;

    // Interlock state codes as they appear on the result channel.
    localparam logic [1:0] LK_CODE_OFF    = 2'd0;
    localparam logic [1:0] LK_CODE_ACTIVE = 2'd1;
    localparam logic [1:0] LK_CODE_WAIT   = 2'd2;

    localparam int CFG_DATA_W = 16;
    localparam int VEL_W      = 13;
    localparam int TIME_W     = 32;
    localparam int PAUSE_W    = 16;
    localparam int POL_W      = 2;

    typedef enum logic [1:0] {
        CFG_MAX_DUTY  = 2'd0,
        CFG_PAUSE_MS  = 2'd1,
        CFG_FRONT_POL = 2'd2,
        CFG_BACK_POL  = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        LK_OFF    = 3'b001,
        LK_ACTIVE = 3'b010,
        LK_WAIT   = 3'b100
    } t_lock;

    typedef struct packed {
        t_lock              lock;
        logic [1:0]         active_dir;
        logic [1:0]         wait_dir;
        logic [1:0]         last_dir;
        logic [TIME_W-1:0]  off_since;
        logic               off_rec;
    } t_lock_st;

    function automatic logic [1:0] lock_code(input t_lock lk);
        logic [1:0] code;
        case (lk)
            LK_ACTIVE: code = LK_CODE_ACTIVE;
            LK_WAIT:   code = LK_CODE_WAIT;
            default:   code = LK_CODE_OFF;
        endcase
        return code;
    endfunction

    // Returns {reverse_enable, forward_enable} for one bridge. A zero polarity
    // disables the bridge; a set sign bit swaps the two inputs.
    function automatic logic [1:0] route_sel(input logic [1:0] dir,
                                             input logic [POL_W-1:0] pol);
        logic [1:0] sel;
        sel = 2'b00;
        if (pol != '0 && dir != DIR_STOP) begin
            if ((dir == DIR_FWD) ^ pol[POL_W-1]) begin
                sel = 2'b01;
            end else begin
                sel = 2'b10;
            end
        end
        return sel;
    endfunction

endpackage

@@ rtl/hbri_if.sv @@
`timescale 1ns / 1ps

interface hbri_in_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [12:0] velocity;
    logic [31:0] now_ms;

    modport source (output valid, kind, velocity, now_ms, input ready);
    modport sink   (input valid, kind, velocity, now_ms, output ready);
endinterface

interface hbri_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

interface hbri_out_if #(parameter int DUTY_WIDTH = 8);
    logic                  valid;
    logic                  ready;
    logic [DUTY_WIDTH-1:0] applied_duty;
    logic [1:0]            applied_direction;
    logic [1:0]            interlock_state;
    logic [1:0]            pending_direction;
    logic [DUTY_WIDTH-1:0] front_forward_duty;
    logic [DUTY_WIDTH-1:0] front_reverse_duty;
    logic [DUTY_WIDTH-1:0] back_forward_duty;
    logic [DUTY_WIDTH-1:0] back_reverse_duty;

    modport source (output valid, applied_duty, applied_direction, interlock_state,
                    pending_direction, front_forward_duty, front_reverse_duty,
                    back_forward_duty, back_reverse_duty, input ready);
    modport sink   (input valid, applied_duty, applied_direction, interlock_state,
                    pending_direction, front_forward_duty, front_reverse_duty,
                    back_forward_duty, back_reverse_duty, output ready);
endinterface

@@ rtl/hbri_core.sv @@
`timescale 1ns / 1ps

module hbri_core import hbri_pkg::*; #(
    parameter int DUTY_WIDTH = 8
) (
    input  logic                   i_kind,
    input  logic [VEL_W-1:0]       i_velocity,
    input  logic [TIME_W-1:0]      i_now_ms,
    input  logic [DUTY_WIDTH-1:0]  i_max_duty,
    input  logic [PAUSE_W-1:0]     i_pause_ms,
    input  logic [POL_W-1:0]       i_front_pol,
    input  logic [POL_W-1:0]       i_back_pol,
    input  t_lock_st               i_st,
    output t_lock_st               o_st,
    output logic [DUTY_WIDTH-1:0]  o_duty,
    output logic [1:0]             o_dir,
    output logic [DUTY_WIDTH-1:0]  o_front_fwd,
    output logic [DUTY_WIDTH-1:0]  o_front_rev,
    output logic [DUTY_WIDTH-1:0]  o_back_fwd,
    output logic [DUTY_WIDTH-1:0]  o_back_rev
);

    localparam int CMP_W = (DUTY_WIDTH > VEL_W + 1) ? DUTY_WIDTH : VEL_W + 1;

    logic [VEL_W:0]          vel_mag;
    logic [CMP_W-1:0]        mag_ext;
    logic [CMP_W-1:0]        lim_ext;
    logic [CMP_W-1:0]        sat_mag;
    logic [DUTY_WIDTH-1:0]   req_duty;
    logic [1:0]              req_dir;
    logic                    in_pause;
    logic [1:0]              front_sel;
    logic [1:0]              back_sel;

    // Magnitude of the request, clipped to the configured limit.
    assign vel_mag  = i_velocity[VEL_W-1] ? ((VEL_W+1)'(0) - {1'b1, i_velocity})
                                          : {1'b0, i_velocity};
    assign mag_ext  = CMP_W'(vel_mag);
    assign lim_ext  = CMP_W'(i_max_duty);
    assign sat_mag  = (mag_ext > lim_ext) ? lim_ext : mag_ext;
    assign req_duty = DUTY_WIDTH'(sat_mag);
    assign req_dir  = (i_kind || sat_mag == '0) ? DIR_STOP
                    : (i_velocity[VEL_W-1] ? DIR_REV : DIR_FWD);

    assign in_pause = (i_now_ms - i_st.off_since) < TIME_W'(i_pause_ms);

    always_comb begin
        o_st   = i_st;
        o_dir  = DIR_STOP;
        o_duty = '0;
        if (req_dir == DIR_STOP) begin
            if (i_st.lock == LK_ACTIVE && i_st.active_dir != DIR_STOP) begin
                o_st.last_dir  = i_st.active_dir;
                o_st.off_since = i_now_ms;
                o_st.off_rec   = 1'b1;
            end
            o_st.active_dir = DIR_STOP;
            o_st.wait_dir   = DIR_STOP;
            o_st.lock       = LK_OFF;
        end else begin
            case (i_st.lock)
                LK_ACTIVE: begin
                    if (req_dir == i_st.active_dir) begin
                        o_dir  = i_st.active_dir;
                        o_duty = req_duty;
                    end else begin
                        o_st.last_dir   = i_st.active_dir;
                        o_st.off_since  = i_now_ms;
                        o_st.off_rec    = 1'b1;
                        o_st.active_dir = DIR_STOP;
                        o_st.wait_dir   = req_dir;
                        o_st.lock       = LK_WAIT;
                    end
                end
                LK_WAIT: begin
                    o_st.wait_dir = req_dir;
                    if (!in_pause) begin
                        o_st.active_dir = req_dir;
                        o_st.wait_dir   = DIR_STOP;
                        o_st.lock       = LK_ACTIVE;
                        o_dir           = req_dir;
                        o_duty          = req_duty;
                    end
                end
                LK_OFF: begin
                    if (i_st.off_rec && i_st.last_dir != DIR_STOP &&
                        req_dir != i_st.last_dir && in_pause) begin
                        o_st.wait_dir = req_dir;
                        o_st.lock     = LK_WAIT;
                    end else begin
                        o_st.active_dir = req_dir;
                        o_st.wait_dir   = DIR_STOP;
                        o_st.lock       = LK_ACTIVE;
                        o_dir           = req_dir;
                        o_duty          = req_duty;
                    end
                end
                default: begin
                    o_st.active_dir = DIR_STOP;
                    o_st.wait_dir   = DIR_STOP;
                    o_st.lock       = LK_OFF;
                end
            endcase
        end
    end

    assign front_sel   = route_sel(o_dir, i_front_pol);
    assign back_sel    = route_sel(o_dir, i_back_pol);
    assign o_front_fwd = front_sel[0] ? o_duty : '0;
    assign o_front_rev = front_sel[1] ? o_duty : '0;
    assign o_back_fwd  = back_sel[0]  ? o_duty : '0;
    assign o_back_rev  = back_sel[1]  ? o_duty : '0;

endmodule

@@ rtl/hbridge_reversal_interlock.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Handshake      Payload
// i_in      in         valid/ready    kind, velocity, now_ms
// i_cfg     in         valid/ready    index, data (always ready)
// o_out     out        valid/ready    duty, direction, lock state, pending, bridge duties
//
// A request accepted into the input register moves on to the result register
// once that register is empty or being drained, and its result is then held
// on o_out until taken. A new request is accepted every cycle while results
// are being taken; the interlock state register closes its loop through the
// core's combinational logic, so each request sees the state left by the last.
// Reset (synchronous, active low) empties both registers and returns the
// interlock to off with reset configuration. A stalled result holds the input
// register, and the input side stalls only when both registers are full.

module hbridge_reversal_interlock import hbri_pkg::*; #(
    parameter int DUTY_WIDTH = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hbri_in_if.sink    i_in,
    hbri_cfg_if.sink   i_cfg,
    hbri_out_if.source o_out
);

    // Configuration registers. The duty limit is eight bits wide at the port
    // and is cut or widened to the duty width here.
    logic [DUTY_WIDTH-1:0] r_max_duty;
    logic [PAUSE_W-1:0]    r_pause_ms;
    logic [POL_W-1:0]      r_front_pol;
    logic [POL_W-1:0]      r_back_pol;
    logic [DUTY_WIDTH+7:0] cfg_duty_ext;
    logic [DUTY_WIDTH+7:0] rst_duty_ext;

    // Input register.
    logic                  r_in_valid;
    logic                  r_kind;
    logic [VEL_W-1:0]      r_velocity;
    logic [TIME_W-1:0]     r_now_ms;

    // Interlock state.
    t_lock_st              r_st;
    t_lock_st              n_st;

    // Result register.
    logic                  r_out_valid;
    logic [DUTY_WIDTH-1:0] r_duty;
    logic [1:0]            r_dir;
    logic [1:0]            r_lock_code;
    logic [1:0]            r_pend;
    logic [DUTY_WIDTH-1:0] r_front_fwd;
    logic [DUTY_WIDTH-1:0] r_front_rev;
    logic [DUTY_WIDTH-1:0] r_back_fwd;
    logic [DUTY_WIDTH-1:0] r_back_rev;

    logic [DUTY_WIDTH-1:0] n_duty;
    logic [1:0]            n_dir;
    logic [DUTY_WIDTH-1:0] n_front_fwd;
    logic [DUTY_WIDTH-1:0] n_front_rev;
    logic [DUTY_WIDTH-1:0] n_back_fwd;
    logic [DUTY_WIDTH-1:0] n_back_rev;

    logic                  advance;
    logic                  in_take;

    // The held request moves into the result register whenever that register
    // is empty or being drained this cycle.
    assign advance  = r_in_valid && (!r_out_valid || o_out.ready);
    assign in_take  = i_in.valid && i_in.ready;
    assign i_in.ready  = !r_in_valid || advance;
    assign i_cfg.ready = 1'b1;

    assign cfg_duty_ext = {DUTY_WIDTH'(0), i_cfg.data[7:0]};
    assign rst_duty_ext = {DUTY_WIDTH'(0), 8'hFF};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_duty  <= rst_duty_ext[DUTY_WIDTH-1:0];
            r_pause_ms  <= PAUSE_W'(250);
            r_front_pol <= POL_W'(1);
            r_back_pol  <= POL_W'(1);
        end else if (i_cfg.valid) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_MAX_DUTY:  r_max_duty  <= cfg_duty_ext[DUTY_WIDTH-1:0];
                CFG_PAUSE_MS:  r_pause_ms  <= i_cfg.data[PAUSE_W-1:0];
                CFG_FRONT_POL: r_front_pol <= i_cfg.data[POL_W-1:0];
                CFG_BACK_POL:  r_back_pol  <= i_cfg.data[POL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_kind     <= i_in.kind;
            r_velocity <= i_in.velocity;
            r_now_ms   <= i_in.now_ms;
        end
    end

    hbri_core #(
        .DUTY_WIDTH (DUTY_WIDTH)
    ) u_core (
        .i_kind      (r_kind),
        .i_velocity  (r_velocity),
        .i_now_ms    (r_now_ms),
        .i_max_duty  (r_max_duty),
        .i_pause_ms  (r_pause_ms),
        .i_front_pol (r_front_pol),
        .i_back_pol  (r_back_pol),
        .i_st        (r_st),
        .o_st        (n_st),
        .o_duty      (n_duty),
        .o_dir       (n_dir),
        .o_front_fwd (n_front_fwd),
        .o_front_rev (n_front_rev),
        .o_back_fwd  (n_back_fwd),
        .o_back_rev  (n_back_rev)
    );

    // The interlock state commits only when a request actually completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.lock       <= LK_OFF;
            r_st.active_dir <= DIR_STOP;
            r_st.wait_dir   <= DIR_STOP;
            r_st.last_dir   <= DIR_STOP;
            r_st.off_since  <= '0;
            r_st.off_rec    <= 1'b0;
        end else if (advance) begin
            r_st <= n_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_duty      <= n_duty;
            r_dir       <= n_dir;
            r_lock_code <= lock_code(n_st.lock);
            r_pend      <= n_st.wait_dir;
            r_front_fwd <= n_front_fwd;
            r_front_rev <= n_front_rev;
            r_back_fwd  <= n_back_fwd;
            r_back_rev  <= n_back_rev;
        end
    end

    assign o_out.valid              = r_out_valid;
    assign o_out.applied_duty       = r_duty;
    assign o_out.applied_direction  = r_dir;
    assign o_out.interlock_state    = r_lock_code;
    assign o_out.pending_direction  = r_pend;
    assign o_out.front_forward_duty = r_front_fwd;
    assign o_out.front_reverse_duty = r_front_rev;
    assign o_out.back_forward_duty  = r_back_fwd;
    assign o_out.back_reverse_duty  = r_back_rev;

endmodule

@@ rtl/hbri_checker.sv @@
`timescale 1ns / 1ps

module hbri_checker import hbri_pkg::*; #(
    parameter int DUTY_WIDTH = 8
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_out_valid,
    input logic                  i_out_ready,
    input logic [DUTY_WIDTH-1:0] i_duty,
    input logic [1:0]            i_dir,
    input logic [1:0]            i_lock,
    input logic [1:0]            i_pend,
    input logic [DUTY_WIDTH-1:0] i_front_fwd,
    input logic [DUTY_WIDTH-1:0] i_front_rev,
    input logic [DUTY_WIDTH-1:0] i_back_fwd,
    input logic [DUTY_WIDTH-1:0] i_back_rev
);

    // A result waiting for the consumer stays put.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_duty) && $stable(i_dir)
            && $stable(i_lock) && $stable(i_pend))
        else $error("result changed while stalled");

    // Drive is applied only in the active state.
    a_drive_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_dir != DIR_STOP |-> i_lock == LK_CODE_ACTIVE)
        else $error("drive applied outside the active state");

    // A pending direction exists exactly while waiting out the pause.
    a_pending_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ((i_pend != DIR_STOP) == (i_lock == LK_CODE_WAIT)))
        else $error("pending direction and wait state disagree");

    // No duty on any bridge input when stopped.
    a_stop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_dir == DIR_STOP |-> i_duty == '0 && i_front_fwd == '0
            && i_front_rev == '0 && i_back_fwd == '0 && i_back_rev == '0)
        else $error("duty present while stopped");

    // A bridge is never driven on both inputs at once.
    a_no_shoot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_front_fwd == '0 || i_front_rev == '0)
            && (i_back_fwd == '0 || i_back_rev == '0))
        else $error("bridge driven both ways");

endmodule

bind hbridge_reversal_interlock hbri_checker #(
    .DUTY_WIDTH (DUTY_WIDTH)
) u_hbri_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_duty      (o_out.applied_duty),
    .i_dir       (o_out.applied_direction),
    .i_lock      (o_out.interlock_state),
    .i_pend      (o_out.pending_direction),
    .i_front_fwd (o_out.front_forward_duty),
    .i_front_rev (o_out.front_reverse_duty),
    .i_back_fwd  (o_out.back_forward_duty),
    .i_back_rev  (o_out.back_reverse_duty)
);
